// File: hw/rtl/jpeg_exif_segment_finder_assert.svh
// assertion macros for the exif segment finder
`ifndef JPEG_EXIF_SEGMENT_FINDER_ASSERT_SVH
`define JPEG_EXIF_SEGMENT_FINDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define JESF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define JESF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/jesf_pkg.sv
package jesf_pkg;

  localparam int POSITION_BITS = 32;
  localparam int OFFSET_BITS   = 32;
  localparam int SUM_BITS      = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] BYTE_SOI  = 8'hD8;
  localparam logic [7:0] BYTE_EOI  = 8'hD9;
  localparam logic [7:0] BYTE_RST0 = 8'hD0;
  localparam logic [7:0] BYTE_RST7 = 8'hD7;
  localparam logic [7:0] BYTE_APP1 = 8'hE1;
  localparam logic [2:0] SIG_LEN   = 3'd6;
  localparam logic [SUM_BITS-1:0] TIFF_SKIP = SUM_BITS'(10);

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_MARK_FF,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                   valid;
    logic                   found;
    logic [OFFSET_BITS-1:0] tiff_offset;
  } result_t;

  // "Exif" 00 00
  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h45;
      3'd1:    val = 8'h78;
      3'd2:    val = 8'h69;
      3'd3:    val = 8'h66;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: hw/rtl/jesf_scan.sv
`include "jpeg_exif_segment_finder_assert.svh"

module jesf_scan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output jesf_pkg::result_t        res
);

  jesf_pkg::phase_t                      phase_r, phase_nxt;
  logic [jesf_pkg::POSITION_BITS-1:0]    pos_r, pos_nxt;
  logic [7:0]                            len_hi_r, len_hi_nxt;
  logic [15:0]                           remain_r, remain_nxt;
  logic [2:0]                            sig_idx_r, sig_idx_nxt;
  logic                                  sig_ok_r, sig_ok_nxt;
  logic [jesf_pkg::OFFSET_BITS-1:0]      pend_off_r, pend_off_nxt;

  logic [15:0]                           seg_len;
  logic                                  standalone;
  logic                                  sig_ok_upd;
  logic                                  decided;
  logic                                  hit;
  logic [jesf_pkg::SUM_BITS-1:0]         off_sum;

  assign seg_len    = {len_hi_r, data_byte};
  assign standalone = (data_byte == jesf_pkg::BYTE_SOI) || (data_byte == jesf_pkg::BYTE_EOI) ||
                      ((data_byte >= jesf_pkg::BYTE_RST0) && (data_byte <= jesf_pkg::BYTE_RST7));
  assign sig_ok_upd = sig_ok_r &&
                      ((sig_idx_r >= jesf_pkg::SIG_LEN) ||
                       (data_byte == jesf_pkg::exif_sig(sig_idx_r)));
  assign off_sum    = jesf_pkg::SUM_BITS'(pos_r) + jesf_pkg::TIFF_SKIP;

  // decision for the current byte
  always_comb begin
    decided = 1'b0;
    hit     = 1'b0;
    unique case (phase_r)
      jesf_pkg::PH_START0:  decided = (data_byte != jesf_pkg::BYTE_FF);
      jesf_pkg::PH_START1:  decided = (data_byte != jesf_pkg::BYTE_SOI);
      jesf_pkg::PH_MARK_FF: decided = (data_byte != jesf_pkg::BYTE_FF);
      jesf_pkg::PH_MARKER:  decided = standalone;
      jesf_pkg::PH_LEN_HI:  decided = 1'b0;
      jesf_pkg::PH_LEN_LO:  decided = (seg_len[15:1] == 15'd0);
      jesf_pkg::PH_PAYLOAD: begin
        hit     = (remain_r == 16'd1) && sig_ok_upd;
        decided = hit;
      end
      jesf_pkg::PH_DONE:    decided = 1'b0;
      default:              decided = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      priority if (last_byte) begin
        phase_nxt = jesf_pkg::PH_START0;
      end else if (phase_r == jesf_pkg::PH_DONE || decided) begin
        phase_nxt = jesf_pkg::PH_DONE;
      end else begin
        unique case (phase_r)
          jesf_pkg::PH_START0:  phase_nxt = jesf_pkg::PH_START1;
          jesf_pkg::PH_START1:  phase_nxt = jesf_pkg::PH_MARK_FF;
          jesf_pkg::PH_MARK_FF: phase_nxt = jesf_pkg::PH_MARKER;
          jesf_pkg::PH_MARKER:  phase_nxt = jesf_pkg::PH_LEN_HI;
          jesf_pkg::PH_LEN_HI:  phase_nxt = jesf_pkg::PH_LEN_LO;
          jesf_pkg::PH_LEN_LO:  phase_nxt = (seg_len == 16'd2) ? jesf_pkg::PH_MARK_FF
                                                              : jesf_pkg::PH_PAYLOAD;
          jesf_pkg::PH_PAYLOAD: phase_nxt = (remain_r == 16'd1) ? jesf_pkg::PH_MARK_FF
                                                                : jesf_pkg::PH_PAYLOAD;
          default:              phase_nxt = jesf_pkg::PH_DONE;
        endcase
      end
    end
  end

  // datapath state and result
  always_comb begin
    pos_nxt      = pos_r;
    len_hi_nxt   = len_hi_r;
    remain_nxt   = remain_r;
    sig_idx_nxt  = sig_idx_r;
    sig_ok_nxt   = sig_ok_r;
    pend_off_nxt = pend_off_r;
    res.valid       = step && (phase_r != jesf_pkg::PH_DONE) && (decided || last_byte);
    res.found       = hit;
    res.tiff_offset = hit ? pend_off_r : '0;
    if (step) begin
      priority if (last_byte) begin
        pos_nxt      = '0;
        len_hi_nxt   = '0;
        remain_nxt   = '0;
        sig_idx_nxt  = '0;
        sig_ok_nxt   = 1'b0;
        pend_off_nxt = '0;
      end else begin
        pos_nxt = pos_r + jesf_pkg::POSITION_BITS'(1);
        unique case (phase_r)
          jesf_pkg::PH_MARK_FF: pend_off_nxt = off_sum[jesf_pkg::OFFSET_BITS-1:0];
          jesf_pkg::PH_MARKER: begin
            sig_ok_nxt  = (data_byte == jesf_pkg::BYTE_APP1);
            sig_idx_nxt = '0;
          end
          jesf_pkg::PH_LEN_HI:  len_hi_nxt = data_byte;
          jesf_pkg::PH_LEN_LO: begin
            if (seg_len[15:3] == 13'd0) begin
              sig_ok_nxt = 1'b0;
            end
            remain_nxt = seg_len - 16'd2;
          end
          jesf_pkg::PH_PAYLOAD: begin
            sig_ok_nxt = sig_ok_upd;
            if (sig_idx_r < jesf_pkg::SIG_LEN) begin
              sig_idx_nxt = sig_idx_r + 3'd1;
            end
            remain_nxt = remain_r - 16'd1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jesf_pkg::PH_START0;
      pos_r      <= '0;
      len_hi_r   <= '0;
      remain_r   <= '0;
      sig_idx_r  <= '0;
      sig_ok_r   <= 1'b0;
      pend_off_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      len_hi_r   <= len_hi_nxt;
      remain_r   <= remain_nxt;
      sig_idx_r  <= sig_idx_nxt;
      sig_ok_r   <= sig_ok_nxt;
      pend_off_r <= pend_off_nxt;
    end
  end

  `JESF_ASSERT_NEXT(a_rearm_on_last, step && last_byte,
    (phase_r == jesf_pkg::PH_START0) && (pos_r == '0), "scan did not rearm after last byte")
  `JESF_ASSERT_NOW(a_done_silent, step && (phase_r == jesf_pkg::PH_DONE),
    !res.valid, "result given after decision")
  `JESF_ASSERT_NOW(a_found_in_payload, res.valid && res.found,
    (phase_r == jesf_pkg::PH_PAYLOAD) && (remain_r == 16'd1), "found outside segment end")

endmodule

// File: hw/rtl/jpeg_exif_segment_finder.sv
// Exif APP1 segment finder for a JPEG byte stream.
// Input channel: in_valid / in_stall with in_data_byte and in_last_byte,
// one file byte per request, in_last_byte on the file's final byte.
// Result channel: out_valid / out_stall with out_found and out_tiff_offset.
// Exactly one result request per file: found with the TIFF header offset
// (segment start plus 10), or not found with offset 0. A result appears as
// soon as the outcome is known, or on the last byte if still undecided.
// A byte goes from the input register through the scan logic into the
// result register (or the second slot when the output is stalled).
// Throughput: one byte per cycle while in_stall is low.
// A stalled result sits in the output register while a second slot takes
// the next result, so bytes keep flowing; in_stall rises only when both
// slots are full and the input register holds a byte.
// After a result, bytes up to the last byte are consumed without output;
// the block then rearms for a new file at offset 0.
// Reset (rst_n low, synchronous) empties all stages and rearms the scan.
`include "jpeg_exif_segment_finder_assert.svh"

module jpeg_exif_segment_finder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_last_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [jesf_pkg::OFFSET_BITS-1:0]    out_tiff_offset
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;
  logic                  adv;
  logic                  in_acc;
  logic                  pop;
  logic                  push;
  jesf_pkg::result_t     scan_res;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [jesf_pkg::OFFSET_BITS-1:0] out_off_r;
  logic                  skid_valid_r, skid_valid_nxt;
  logic                  skid_found_r;
  logic [jesf_pkg::OFFSET_BITS-1:0] skid_off_r;

  assign adv      = s1_valid_r && !skid_valid_r;
  assign in_stall = s1_valid_r && skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid_r && !out_stall;
  assign push     = scan_res.valid;

  jesf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .res       (scan_res)
  );

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !adv);
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      out_valid_nxt  = skid_valid_r || push;
      skid_valid_nxt = 1'b0;
    end else if (push) begin
      out_valid_nxt  = 1'b1;
      skid_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (pop && skid_valid_r) begin
      out_found_r <= skid_found_r;
      out_off_r   <= skid_off_r;
    end else if (push && (pop || !out_valid_r)) begin
      out_found_r <= scan_res.found;
      out_off_r   <= scan_res.tiff_offset;
    end
    if (push && out_valid_r && !pop) begin
      skid_found_r <= scan_res.found;
      skid_off_r   <= scan_res.tiff_offset;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_tiff_offset = out_off_r;

  `JESF_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
    "second result slot used while output empty")
  `JESF_ASSERT_NOW(a_not_found_zero, out_valid_r && !out_found_r,
    out_off_r == '0, "offset nonzero on not-found result")
  `JESF_ASSERT_NEXT(a_stalled_push_kept, push && out_valid_r && out_stall,
    skid_valid_r && out_valid_r, "result lost while output stalled")

endmodule
